// ----- rtl/latency_stat_tracker_assert.svh -----
// Assertion macros for the latency statistics tracker.
`ifndef LATENCY_STAT_TRACKER_ASSERT_SVH
`define LATENCY_STAT_TRACKER_ASSERT_SVH
`ifndef SYNTH
`define LST_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LST_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LST_ASSERT_IMP(label, ante, cons)
`define LST_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/lst_pkg.sv -----
// Shared types and constants for the latency statistics tracker.
package lst_pkg;

    localparam int NUM_TYPES = 8;
    localparam int TYPE_W    = 3;
    localparam int IDX_W     = $clog2(NUM_TYPES);
    localparam int DATA_W    = 64;
    localparam int CNT_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int MUL_STEPS = DATA_W / 2;
    localparam int DIV_STEPS = DATA_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ORDER    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_DIV = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic              action;
        logic [TYPE_W-1:0] event_type;
        logic [DATA_W-1:0] start_time;
        logic [DATA_W-1:0] end_time;
        logic [CNT_W-1:0]  completed_events;
    } sample_t;

    typedef struct packed {
        logic [TYPE_W-1:0]   row_type;
        logic [DATA_W-1:0]   total_events;
        logic [DATA_W-1:0]   mean_latency;
        logic [DATA_W-1:0]   peak_latency;
        logic [DATA_W-1:0]   least_latency;
        logic [DATA_W-1:0]   sample_latency;
        logic [STATUS_W-1:0] status;
    } report_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] multiplicand;
        logic [DATA_W-1:0] multiplier;
        logic [DATA_W-1:0] addend;
        logic [DATA_W-1:0] divisor;
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } md_rsp_t;

endpackage

// ----- rtl/lst_muldiv.sv -----
// Serial unit: (multiplicand * multiplier + addend) / divisor, quotient saturated.
module lst_muldiv (
    input  logic            clk,
    input  logic            rst_n,
    input  lst_pkg::md_req_t req,
    output lst_pkg::md_rsp_t rsp
);

    localparam logic [2:0] MD_IDLE = 3'd0;
    localparam logic [2:0] MD_PRE  = 3'd1;
    localparam logic [2:0] MD_MUL  = 3'd2;
    localparam logic [2:0] MD_ADD  = 3'd3;
    localparam logic [2:0] MD_INC  = 3'd4;
    localparam logic [2:0] MD_CHK  = 3'd5;
    localparam logic [2:0] MD_DIV  = 3'd6;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [lst_pkg::STEP_W-1:0]    count_reg;
    logic [lst_pkg::DATA_W-1:0]    mcand_reg;
    logic [lst_pkg::DATA_W+1:0]    mcand3_reg;
    logic [lst_pkg::DATA_W-1:0]    mplier_reg;
    logic [lst_pkg::DATA_W-1:0]    addend_reg;
    logic [lst_pkg::DATA_W-1:0]    divisor_reg;
    logic [lst_pkg::DATA_W-1:0]    hi_reg;
    logic [lst_pkg::DATA_W-1:0]    lo_reg;
    logic                          carry_reg;
    logic [lst_pkg::DATA_W-1:0]    quot_reg;
    logic                          done_reg;

    logic [lst_pkg::DATA_W+1:0]    digit_mult;
    logic [lst_pkg::DATA_W+1:0]    mul_sum;
    logic [lst_pkg::DATA_W:0]      lo_sum;
    logic [lst_pkg::DATA_W:0]      rem_shift;
    logic [lst_pkg::DATA_W+1:0]    rem_diff;
    logic                          rem_ge;
    logic                          mul_last;
    logic                          div_last;

    always_comb
    begin
        case (mplier_reg[1:0])
            2'd0:    digit_mult = '0;
            2'd1:    digit_mult = {2'b00, mcand_reg};
            2'd2:    digit_mult = {1'b0, mcand_reg, 1'b0};
            default: digit_mult = mcand3_reg;
        endcase
    end

    assign mul_sum   = {2'b00, hi_reg} + digit_mult;
    assign lo_sum    = {1'b0, lo_reg} + {1'b0, addend_reg};
    assign rem_shift = {hi_reg, lo_reg[lst_pkg::DATA_W-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, divisor_reg};
    assign rem_ge    = !rem_diff[lst_pkg::DATA_W+1];
    assign mul_last  = (count_reg == lst_pkg::STEP_W'(lst_pkg::MUL_STEPS - 1));
    assign div_last  = (count_reg == lst_pkg::STEP_W'(lst_pkg::DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE: if (req.start) state_next = MD_PRE;
            MD_PRE:  state_next = MD_MUL;
            MD_MUL:  if (mul_last) state_next = MD_ADD;
            MD_ADD:  state_next = MD_INC;
            MD_INC:  state_next = MD_CHK;
            MD_CHK:  state_next = (hi_reg >= divisor_reg) ? MD_IDLE : MD_DIV;
            MD_DIV:  if (div_last) state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == MD_CHK) && (hi_reg >= divisor_reg))
                         || ((state_reg == MD_DIV) && div_last);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    mcand_reg   <= req.multiplicand;
                    mplier_reg  <= req.multiplier;
                    addend_reg  <= req.addend;
                    divisor_reg <= req.divisor;
                end
            end
            MD_PRE:
            begin
                mcand3_reg <= {2'b00, mcand_reg} + {1'b0, mcand_reg, 1'b0};
                hi_reg     <= '0;
                lo_reg     <= '0;
                count_reg  <= '0;
            end
            MD_MUL:
            begin
                hi_reg     <= mul_sum[lst_pkg::DATA_W+1:2];
                lo_reg     <= {mul_sum[1:0], lo_reg[lst_pkg::DATA_W-1:2]};
                mplier_reg <= {2'b00, mplier_reg[lst_pkg::DATA_W-1:2]};
                count_reg  <= count_reg + 1'b1;
            end
            MD_ADD:
            begin
                lo_reg    <= lo_sum[lst_pkg::DATA_W-1:0];
                carry_reg <= lo_sum[lst_pkg::DATA_W];
            end
            MD_INC:
            begin
                hi_reg <= hi_reg + {{(lst_pkg::DATA_W-1){1'b0}}, carry_reg};
            end
            MD_CHK:
            begin
                count_reg <= '0;
                // high half at or above divisor: quotient overflows 64 bits
                if (hi_reg >= divisor_reg)
                    quot_reg <= lst_pkg::ALL_ONES;
            end
            MD_DIV:
            begin
                hi_reg    <= rem_ge ? rem_diff[lst_pkg::DATA_W-1:0]
                                    : rem_shift[lst_pkg::DATA_W-1:0];
                lo_reg    <= {lo_reg[lst_pkg::DATA_W-2:0], rem_ge};
                count_reg <= count_reg + 1'b1;
                if (div_last)
                    quot_reg <= {lo_reg[lst_pkg::DATA_W-2:0], rem_ge};
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// ----- rtl/latency_stat_tracker.sv -----
// Latency statistics tracker: per event type total, mean, peak and least latency.
//
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one item per
//   transfer: action 0 records a latency sample for one event type, action 1
//   clears every row. report channel (report_valid / report_stall / report)
//   returns exactly one result per item, in order.
// Sequencing:
//   one item at a time; sample_stall is high from a transfer until its result
//   is loaded into the report register. A record item's mean is set by the
//   serial multiply (two bits per cycle) and restoring divide (one bit per
//   cycle); a mean that overflows skips the divide. Clear and out of range
//   items skip the sum and the multiply-divide; a zero divisor skips the
//   multiply-divide.
// Reset:
//   all rows read back as total 0, mean 0, peak 0, least all ones.
// Stalls:
//   a result waits in the report register while report_stall is high; the
//   next item can be taken and worked on meanwhile, but its result is held
//   until the register frees up.
module latency_stat_tracker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  lst_pkg::sample_t sample,
    output logic             report_valid,
    input  logic             report_stall,
    output lst_pkg::report_t report
);

    `include "latency_stat_tracker_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    lst_pkg::sample_t                 item_reg;
    logic [lst_pkg::NUM_TYPES-1:0]    row_valid_reg;
    logic                             start_reg;
    logic                             report_valid_reg;
    lst_pkg::report_t                 report_reg;

    logic [lst_pkg::DATA_W-1:0]       total_mem [lst_pkg::NUM_TYPES];
    logic [lst_pkg::DATA_W-1:0]       mean_mem  [lst_pkg::NUM_TYPES];
    logic [lst_pkg::DATA_W-1:0]       peak_mem  [lst_pkg::NUM_TYPES];
    logic [lst_pkg::DATA_W-1:0]       least_mem [lst_pkg::NUM_TYPES];

    logic [lst_pkg::DATA_W-1:0]       old_reg;
    logic [lst_pkg::DATA_W-1:0]       mean_reg;
    logic [lst_pkg::DATA_W-1:0]       peak_reg;
    logic [lst_pkg::DATA_W-1:0]       least_reg;
    logic [lst_pkg::DATA_W-1:0]       delta_reg;
    logic                             order_reg;
    logic [lst_pkg::DATA_W-1:0]       sum_reg;
    logic                             zdiv_reg;

    logic                             accept;
    logic                             out_free;
    logic                             wb_fire;
    logic                             in_range;
    logic                             is_clear;
    logic [lst_pkg::IDX_W-1:0]        idx;
    logic [lst_pkg::DATA_W:0]         delta_full;
    logic [lst_pkg::DATA_W:0]         sum_full;
    logic [lst_pkg::DATA_W-1:0]       sum_sat;
    logic [lst_pkg::DATA_W-1:0]       peak_new;
    logic [lst_pkg::DATA_W-1:0]       least_new;
    logic [lst_pkg::STATUS_W-1:0]     order_status;
    lst_pkg::md_req_t                 md_req;
    lst_pkg::md_rsp_t                 md_rsp;

    assign accept    = sample_valid && !sample_stall;
    assign out_free  = !report_valid_reg || !report_stall;
    assign wb_fire   = (state_reg == S_WB) && out_free;
    assign in_range  = (int'(item_reg.event_type) < lst_pkg::NUM_TYPES);
    assign is_clear  = (item_reg.action == lst_pkg::ACT_CLEAR);
    assign idx       = item_reg.event_type[lst_pkg::IDX_W-1:0];

    assign delta_full = {1'b0, item_reg.end_time} - {1'b0, item_reg.start_time};
    assign sum_full   = {1'b0, old_reg}
                        + {{(lst_pkg::DATA_W-lst_pkg::CNT_W+1){1'b0}},
                           item_reg.completed_events};
    assign sum_sat    = sum_full[lst_pkg::DATA_W] ? lst_pkg::ALL_ONES
                                                  : sum_full[lst_pkg::DATA_W-1:0];
    assign peak_new   = (delta_reg > peak_reg) ? delta_reg : peak_reg;
    assign least_new  = (delta_reg < least_reg) ? delta_reg : least_reg;
    assign order_status = order_reg ? lst_pkg::ST_ORDER : lst_pkg::ST_OK;

    assign md_req.start        = start_reg;
    assign md_req.multiplicand = mean_reg;
    assign md_req.multiplier   = old_reg;
    assign md_req.addend       = delta_reg;
    assign md_req.divisor      = sum_reg;

    lst_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_PREP;
            S_PREP: state_next = (is_clear || !in_range) ? S_WB : S_SUM;
            S_SUM:  state_next = (sum_sat == '0) ? S_WB : S_WAIT;
            S_WAIT: if (md_rsp.done) state_next = S_WB;
            S_WB:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            row_valid_reg    <= '0;
            start_reg        <= 1'b0;
            report_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= (state_reg == S_SUM) && (sum_sat != '0);
            if (wb_fire)
                report_valid_reg <= 1'b1;
            else if (!report_stall)
                report_valid_reg <= 1'b0;
            if (wb_fire)
            begin
                if (is_clear)
                    row_valid_reg <= '0;
                else if (in_range)
                    row_valid_reg[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= sample;

        if (state_reg == S_PREP)
        begin
            delta_reg <= delta_full[lst_pkg::DATA_W-1:0];
            order_reg <= delta_full[lst_pkg::DATA_W];
            zdiv_reg  <= 1'b0;
            if (row_valid_reg[idx])
            begin
                old_reg   <= total_mem[idx];
                mean_reg  <= mean_mem[idx];
                peak_reg  <= peak_mem[idx];
                least_reg <= least_mem[idx];
            end
            else
            begin
                old_reg   <= '0;
                mean_reg  <= '0;
                peak_reg  <= '0;
                least_reg <= lst_pkg::ALL_ONES;
            end
        end

        if (state_reg == S_SUM)
        begin
            sum_reg  <= sum_sat;
            zdiv_reg <= (sum_sat == '0);
        end

        if ((state_reg == S_WAIT) && md_rsp.done)
            mean_reg <= md_rsp.quotient;

        if (wb_fire && !is_clear && in_range)
        begin
            total_mem[idx] <= sum_reg;
            mean_mem[idx]  <= mean_reg;
            peak_mem[idx]  <= peak_new;
            least_mem[idx] <= least_new;
        end

        if (wb_fire)
        begin
            report_reg.row_type <= item_reg.event_type;
            if (is_clear)
            begin
                report_reg.total_events   <= '0;
                report_reg.mean_latency   <= '0;
                report_reg.peak_latency   <= '0;
                report_reg.least_latency  <= lst_pkg::ALL_ONES;
                report_reg.sample_latency <= '0;
                report_reg.status         <= lst_pkg::ST_CLEARED;
            end
            else if (!in_range)
            begin
                report_reg.total_events   <= '0;
                report_reg.mean_latency   <= '0;
                report_reg.peak_latency   <= '0;
                report_reg.least_latency  <= lst_pkg::ALL_ONES;
                report_reg.sample_latency <= delta_reg;
                report_reg.status         <= order_status;
            end
            else
            begin
                report_reg.total_events   <= sum_reg;
                report_reg.mean_latency   <= mean_reg;
                report_reg.peak_latency   <= peak_new;
                report_reg.least_latency  <= least_new;
                report_reg.sample_latency <= delta_reg;
                report_reg.status         <= zdiv_reg ? lst_pkg::ST_ZERO_DIV : order_status;
            end
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign report_valid = report_valid_reg;
    assign report       = report_reg;

    `LST_ASSERT_NXT(a_busy_after_transfer, accept, sample_stall)
    `LST_ASSERT_IMP(a_clear_report, report_valid && (report.status == lst_pkg::ST_CLEARED), (report.total_events == '0) && (report.least_latency == lst_pkg::ALL_ONES))
    `LST_ASSERT_IMP(a_peak_over_least, report_valid && (report.total_events != '0), report.peak_latency >= report.least_latency)

endmodule

// ----- bench/latency_row_checker.sv -----
// Checker for latency_stat_tracker: tracks per-row statistics and compares every report.
module latency_row_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    input  logic             sample_stall,
    input  lst_pkg::sample_t sample,
    input  logic             report_valid,
    input  logic             report_stall,
    input  lst_pkg::report_t report,
    output int               errors,
    output int               outstanding,
    output int               checked,
    output int               clears,
    output int               zero_divs,
    output int               reversed
);
    import lst_pkg::*;

    logic [DATA_W-1:0] row_total [NUM_TYPES];
    logic [DATA_W-1:0] row_mean  [NUM_TYPES];
    logic [DATA_W-1:0] row_peak  [NUM_TYPES];
    logic [DATA_W-1:0] row_least [NUM_TYPES];

    report_t expected_reports[$];

    task automatic report_error(input string msg);
        errors++;
        $display("[%0t] report %0d: %s", $realtime, checked, msg);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic wipe_rows();
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            row_total[i] = '0;
            row_mean[i]  = '0;
            row_peak[i]  = '0;
            row_least[i] = ALL_ONES;
        end
    endtask

    // Applies one sample to the row table and returns the report it should produce.
    task automatic fold_sample(input sample_t s, output report_t r);
        logic [DATA_W-1:0]   delta;
        logic [DATA_W-1:0]   old_total;
        logic [DATA_W-1:0]   new_total;
        logic [2*DATA_W-1:0] weighted;
        logic [2*DATA_W-1:0] quotient;

        delta            = s.end_time - s.start_time;
        r.row_type       = s.event_type;
        r.sample_latency = delta;
        r.status         = (s.start_time > s.end_time) ? ST_ORDER : ST_OK;
        r.total_events   = '0;
        r.mean_latency   = '0;
        r.peak_latency   = '0;
        r.least_latency  = ALL_ONES;

        if (s.action == ACT_CLEAR)
        begin
            wipe_rows();
            r.sample_latency = '0;
            r.status         = ST_CLEARED;
        end
        else if (s.event_type < NUM_TYPES)
        begin
            old_total = row_total[s.event_type];
            new_total = old_total + DATA_W'(s.completed_events);
            if (new_total < old_total)
                new_total = ALL_ONES;
            row_total[s.event_type] = new_total;

            if (new_total == '0)
                r.status = ST_ZERO_DIV;
            else
            begin
                weighted = {{DATA_W{1'b0}}, row_mean[s.event_type]}
                         * {{DATA_W{1'b0}}, old_total}
                         + {{DATA_W{1'b0}}, delta};
                quotient = weighted / {{DATA_W{1'b0}}, new_total};
                row_mean[s.event_type] = (quotient[2*DATA_W-1:DATA_W] != '0)
                                       ? ALL_ONES : quotient[DATA_W-1:0];
            end

            if (delta > row_peak[s.event_type])
                row_peak[s.event_type] = delta;
            if (delta < row_least[s.event_type])
                row_least[s.event_type] = delta;

            r.total_events  = row_total[s.event_type];
            r.mean_latency  = row_mean[s.event_type];
            r.peak_latency  = row_peak[s.event_type];
            r.least_latency = row_least[s.event_type];
        end
    endtask

    task automatic compare_report(input report_t got, input report_t want);
        check_field("row_type", DATA_W'(got.row_type), DATA_W'(want.row_type));
        check_field("total_events", got.total_events, want.total_events);
        check_field("mean_latency", got.mean_latency, want.mean_latency);
        check_field("peak_latency", got.peak_latency, want.peak_latency);
        check_field("least_latency", got.least_latency, want.least_latency);
        check_field("sample_latency", got.sample_latency, want.sample_latency);
        check_field("status", DATA_W'(got.status), DATA_W'(want.status));
    endtask

    // Sampled on the falling edge: these values are the ones the next rising edge takes.
    always @(negedge clk or negedge rst_n)
    begin : watch
        report_t want;
        if (!rst_n)
        begin
            wipe_rows();
            expected_reports.delete();
            outstanding = 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                fold_sample(sample, want);
                expected_reports.push_back(want);
                case (want.status)
                    ST_CLEARED:  clears++;
                    ST_ZERO_DIV: zero_divs++;
                    ST_ORDER:    reversed++;
                    default:     ;
                endcase
            end
            if (report_valid && !report_stall)
            begin
                if (expected_reports.size() == 0)
                    report_error("transfer with no sample outstanding");
                else
                    compare_report(report, expected_reports.pop_front());
                checked++;
            end
            outstanding = expected_reports.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Top of the latency_stat_tracker testbench: clock, reset, stimulus and verdict.
module tb;
    import lst_pkg::*;

    localparam int DIRECTED_ITEMS = 16;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int CALM_ITEM_LO   = 700;
    localparam int CALM_ITEM_HI   = 1000;
    localparam int HOLD_START     = 20000;
    localparam int HOLD_CYCLES    = 600;
    localparam int CALM_CYCLE_LO  = 80000;
    localparam int CALM_CYCLE_HI  = 110000;
    localparam int QUIET_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 150;

    logic    clk;
    logic    rst_n;
    logic    sample_valid;
    logic    sample_stall;
    sample_t sample;
    logic    report_valid;
    logic    report_stall;
    report_t report;

    int errors;
    int outstanding;
    int checked;
    int clears;
    int zero_divs;
    int reversed;

    latency_stat_tracker u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report)
    );

    latency_row_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report),
        .errors       (errors),
        .outstanding  (outstanding),
        .checked      (checked),
        .clears       (clears),
        .zero_divs    (zero_divs),
        .reversed     (reversed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic sample_t directed_sample(input int idx);
        sample_t s;
        s        = '0;
        s.action = ACT_RECORD;
        case (idx)
            0:  ; // empty row, no events: zero divisor
            1:  begin s.event_type = 1; s.start_time = 5; s.end_time = 3; end
            2:
            begin
                s.event_type = 1; s.end_time = ALL_ONES; s.completed_events = '1;
            end
            3:
            begin
                s.event_type = 1; s.start_time = ALL_ONES; s.completed_events = 1;
            end
            4:
            begin
                s.event_type = 7; s.start_time = ALL_ONES; s.end_time = ALL_ONES;
                s.completed_events = '1;
            end
            5:
            begin
                s.event_type = 2; s.start_time = 100; s.end_time = 1100;
                s.completed_events = 1;
            end
            6:  begin s.event_type = 2; s.end_time = 50; end
            7:
            begin
                s.event_type = 7; s.start_time = 64'h8000_0000_0000_0000;
                s.end_time = 64'h7FFF_FFFF_FFFF_FFFF; s.completed_events = 16'h8000;
            end
            8:
            begin
                s.event_type = 3; s.start_time = 64'h5555_5555_5555_5555;
                s.end_time = 64'hAAAA_AAAA_AAAA_AAAA; s.completed_events = 16'h5555;
            end
            9:
            begin
                s.event_type = 4; s.start_time = 64'hAAAA_AAAA_AAAA_AAAA;
                s.end_time = 64'h5555_5555_5555_5555; s.completed_events = 16'hAAAA;
            end
            10:
            begin
                s.action = ACT_CLEAR; s.event_type = 5;
                s.start_time = {$urandom, $urandom}; s.end_time = {$urandom, $urandom};
                s.completed_events = '1;
            end
            11: begin s.event_type = 2; s.start_time = 10; s.end_time = 20; end
            12: begin s.event_type = 6; s.start_time = 1; end
            13:
            begin
                s.event_type = 5; s.end_time = 1; s.completed_events = 2;
            end
            14: s.action = ACT_CLEAR;
            default:
            begin
                s.start_time = 64'd77; s.end_time = 64'd77; s.completed_events = 1;
            end
        endcase
        return s;
    endfunction

    // Mostly ordinary completions, some reversed or wild timestamps, occasional clears.
    function automatic sample_t random_sample();
        sample_t           s;
        int                pick;
        int                cnt_pick;
        logic [DATA_W-1:0] base;

        pick         = $urandom_range(99);
        cnt_pick     = $urandom_range(99);
        base         = {$urandom, $urandom};
        s.action     = ($urandom_range(99) < 4) ? ACT_CLEAR : ACT_RECORD;
        s.event_type = TYPE_W'($urandom_range(NUM_TYPES - 1));
        if (pick < 60)
        begin
            s.start_time = base;
            s.end_time   = base + DATA_W'($urandom_range(100000));
        end
        else if (pick < 75)
        begin
            s.end_time   = base;
            s.start_time = base + DATA_W'($urandom_range(1, 100000));
        end
        else if (pick < 90)
        begin
            s.start_time = base;
            s.end_time   = {$urandom, $urandom};
        end
        else
        begin
            s.start_time = $urandom_range(1) ? 64'd0 : ALL_ONES;
            s.end_time   = $urandom_range(1) ? base : ALL_ONES;
        end
        if (cnt_pick < 15)
            s.completed_events = '0;
        else if (cnt_pick < 75)
            s.completed_events = CNT_W'($urandom_range(1, 64));
        else
            s.completed_events = CNT_W'($urandom_range(16'hFFFF));
        return s;
    endfunction

    initial
    begin : stimulus
        sample_t item;
        bit      calm;
        bit      taken;

        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < DIRECTED_ITEMS + RANDOM_ITEMS; n++)
        begin
            item = (n < DIRECTED_ITEMS) ? directed_sample(n) : random_sample();
            calm = (n >= CALM_ITEM_LO && n < CALM_ITEM_HI);
            if (!calm && $urandom_range(99) < 20)
            begin
                sample_valid <= 1'b0;
                repeat ($urandom_range(1) ? $urandom_range(1, 4) : $urandom_range(1, 130))
                    @(posedge clk);
            end
            sample       <= item;
            sample_valid <= 1'b1;
            do
            begin
                @(negedge clk);
                taken = !sample_stall;
                @(posedge clk);
            end
            while (!taken);
        end
        sample_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d reports checked: %0d clears, %0d zero-divisor updates, %0d reversed stamps",
                 checked, clears, zero_divs, reversed);
        $display("random stalls on both channels plus one %0d-cycle report hold-off",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("latency_stat_tracker verification clean");
        else
            $display("latency_stat_tracker verification failed");
        $finish;
    end

    initial
    begin : receiver
        int cyc;
        cyc = 0;
        report_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
                report_stall <= 1'b1;
            else if (cyc >= CALM_CYCLE_LO && cyc < CALM_CYCLE_HI)
                report_stall <= 1'b0;
            else
                report_stall <= ($urandom_range(99) < 20);
        end
    end

    // Ends the run when no transfer happens on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(negedge clk);
            if ((sample_valid && !sample_stall) || (report_valid && !report_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("latency_stat_tracker verification failed");
        $finish;
    end

endmodule
